>>> hw/rtl/bfra_pkg.sv
// Shared types and codes for the bounded FIFO running-average block.
// No dependencies.
package bfra_pkg;

   // Command codes on the request channel
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Per-cell control: shift toward the head, or load a new value
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   // Top-level sequencer, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } state_type;

endpackage

>>> hw/rtl/bfra_chan_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; widths come from parameters.
interface bfra_req_if #(
   parameter int VALUE_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface bfra_rsp_if #(
   parameter int VALUE_BITS = 10,
   parameter int OCC_BITS   = 3
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] average;
   logic [VALUE_BITS-1:0] removed_value;
   logic                  error;
   logic [OCC_BITS-1:0]   occupancy;

   modport source (output valid, output average, output removed_value,
                   output error, output occupancy, input ready);
   modport sink   (input valid, input average, input removed_value,
                   input error, input occupancy, output ready);
endinterface

>>> hw/rtl/bfra_cell.sv
// One storage cell of the FIFO chain: loads a new value or takes its neighbor's.
// Depends on bfra_pkg.
module bfra_cell #(
   parameter int VALUE_BITS = 10
) (
   input  logic                    clock,
   input  bfra_pkg::cell_ctrl_type ctrl,
   input  logic [VALUE_BITS-1:0]   load_value,
   input  logic [VALUE_BITS-1:0]   next_value,
   output logic [VALUE_BITS-1:0]   value
);
   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   // load wins: on a full insert the tail cell shifts and loads at once
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = load_value;
      end else if (ctrl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

>>> hw/rtl/bfra_divider.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
module bfra_divider #(
   parameter int DVD_BITS = 13,
   parameter int DVS_BITS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                done,
   output logic [DVD_BITS-1:0] quotient,
   output logic [DVS_BITS-1:0] remainder
);
   localparam int STEP_BITS = $clog2(DVD_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [DVD_BITS-1:0]  dvd_ff, dvd_in;
   logic [DVS_BITS-1:0]  rem_ff, rem_in;
   logic [DVS_BITS-1:0]  dvs_ff, dvs_in;
   logic [DVS_BITS:0]    trial;
   logic                 qbit;

   assign trial = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(DVD_BITS);
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // quotient bits shift in behind the dividend bits
         dvd_in  = {dvd_ff[DVD_BITS-2:0], qbit};
         rem_in  = qbit ? DVS_BITS'(trial - {1'b0, dvs_ff}) : trial[DVS_BITS-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
endmodule

>>> hw/rtl/bounded_fifo_running_average.sv
// Top level: bounded FIFO with running sum and rounded running average.
// Depends on bfra_pkg, bfra_chan_if, bfra_cell, bfra_divider.
//
//   channel | dir | payload                                     | accepted when
//   req     | in  | command, value                              | req.valid & req.ready
//   rsp     | out | average, removed_value, error, occupancy    | rsp.valid & rsp.ready
//
// Remove item: staged in the res registers at accept, then moved to the response
//   register from ST_HOLD. Insert item: the divider forms sum / count, one
//   quotient bit per cycle; the rounded result is staged in the res registers,
//   then moved to the response register before a new request is taken.
// One item is in flight at a time; the response register frees the request side
//   while a finished item waits on rsp.
// Reset (synchronous) empties the queue and clears the sum; cell contents are left.
// A stall on rsp holds the finished item; the next item is only held up once a
//   second result is ready while the first still waits.
module bounded_fifo_running_average #(
   parameter int CAPACITY   = 5,
   parameter int VALUE_BITS = 10
) (
   input logic       clock,
   input logic       reset,
   bfra_req_if.sink   req,
   bfra_rsp_if.source rsp
);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = VALUE_BITS + CNT_W;

   bfra_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   // staged result of the current item
   logic [VALUE_BITS-1:0] res_avg_ff, res_avg_in;
   logic [VALUE_BITS-1:0] res_rem_ff, res_rem_in;
   logic                  res_err_ff, res_err_in;
   logic [CNT_W-1:0]      res_occ_ff, res_occ_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_avg_ff, rsp_avg_in;
   logic [VALUE_BITS-1:0] rsp_rem_ff, rsp_rem_in;
   logic                  rsp_err_ff, rsp_err_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  accept, is_insert, full, empty, pop, push, out_free;
   logic [CNT_W-1:0]      wpos;
   logic [VALUE_BITS-1:0] cell_val [CAPACITY];
   logic [VALUE_BITS-1:0] head_val;

   logic                  div_done;
   logic [SUM_W-1:0]      div_quot;
   logic [CNT_W-1:0]      div_rem;
   logic [CNT_W:0]        twice_rem;
   logic                  round_up;
   logic [VALUE_BITS-1:0] avg_rounded;

   assign req.ready = (state_ff == bfra_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign is_insert = (req.command == bfra_pkg::CMD_INSERT);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign push      = accept && is_insert;
   // insert on a full queue evicts the oldest; remove pops unless empty
   assign pop       = accept && (is_insert ? full : !empty);
   assign wpos      = full ? CNT_W'(CAPACITY - 1) : count_ff;
   assign head_val  = cell_val[0];

   // chain of cells, cell 0 holds the oldest value
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      bfra_pkg::cell_ctrl_type ctrl;
      logic [VALUE_BITS-1:0]   nxt;

      assign ctrl.shift = pop;
      assign ctrl.load  = push && (wpos == CNT_W'(i));
      if (i == CAPACITY - 1) begin : g_tail
         assign nxt = '0;
      end else begin : g_body
         assign nxt = cell_val[i+1];
      end

      bfra_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_value (req.value),
         .next_value (nxt),
         .value      (cell_val[i])
      );
   end

   // running sum and count
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (pop) begin
         sum_in = sum_in - SUM_W'(head_val);
      end
      if (push) begin
         sum_in = sum_in + SUM_W'(req.value);
      end
      if (push && !full) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !is_insert) begin
         count_in = count_ff - 1'b1;
      end
   end

   bfra_divider #(.DVD_BITS(SUM_W), .DVS_BITS(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (push),
      .dividend  (sum_in),
      .divisor   (count_in),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // round half to even: up if 2r > n, or 2r == n and q odd
   assign twice_rem   = {div_rem, 1'b0};
   assign round_up    = (twice_rem > {1'b0, count_ff}) ||
                        ((twice_rem == {1'b0, count_ff}) && div_quot[0]);
   assign avg_rounded = div_quot[VALUE_BITS-1:0] + VALUE_BITS'(round_up);

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      res_avg_in   = res_avg_ff;
      res_rem_in   = res_rem_ff;
      res_err_in   = res_err_ff;
      res_occ_in   = res_occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_occ_in   = rsp_occ_ff;
      case (state_ff)
         bfra_pkg::ST_IDLE: begin
            if (accept) begin
               res_avg_in = '0;
               res_rem_in = '0;
               res_err_in = 1'b0;
               res_occ_in = count_in;
               if (is_insert) begin
                  state_in = bfra_pkg::ST_DIVIDE;
               end else begin
                  state_in = bfra_pkg::ST_HOLD;
                  if (empty) begin
                     res_err_in = 1'b1;
                     res_occ_in = '0;
                  end else begin
                     res_rem_in = head_val;
                  end
               end
            end
         end
         bfra_pkg::ST_DIVIDE: begin
            if (div_done) begin
               res_avg_in = avg_rounded;
               state_in   = bfra_pkg::ST_HOLD;
            end
         end
         bfra_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = res_avg_ff;
               rsp_rem_in   = res_rem_ff;
               rsp_err_in   = res_err_ff;
               rsp_occ_in   = res_occ_ff;
               state_in     = bfra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfra_pkg::ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_avg_ff <= res_avg_in;
      res_rem_ff <= res_rem_in;
      res_err_ff <= res_err_in;
      res_occ_ff <= res_occ_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_rem_ff <= rsp_rem_in;
      rsp_err_ff <= rsp_err_in;
      rsp_occ_ff <= rsp_occ_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.average       = rsp_avg_ff;
   assign rsp.removed_value = rsp_rem_ff;
   assign rsp.error         = rsp_err_ff;
   assign rsp.occupancy     = rsp_occ_ff;
endmodule

>>> hw/rtl/bfra_checker.sv
// Port-level checks for bounded_fifo_running_average, bound to the top level.
// Depends on the top level's ports only.
module bfra_checker #(
   parameter int CAPACITY   = 5,
   parameter int VALUE_BITS = 10
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [VALUE_BITS-1:0]              average,
   input logic [VALUE_BITS-1:0]              removed_value,
   input logic                               error,
   input logic [$clog2(CAPACITY + 1)-1:0]    occupancy
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // failed remove reports nothing else
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error |-> average == '0 && removed_value == '0 && occupancy == '0)
      else $error("error item carries nonzero fields");

   // an item is either an insert or a remove, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> average == '0 || removed_value == '0)
      else $error("average and removed_value both nonzero");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> occupancy <= CNT_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(average) &&
         $stable(removed_value) && $stable(error) && $stable(occupancy))
      else $error("stalled item changed");

   // first edge out of reset shows no item
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind bounded_fifo_running_average bfra_checker #(
   .CAPACITY   (CAPACITY),
   .VALUE_BITS (VALUE_BITS)
) u_bfra_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .average       (rsp.average),
   .removed_value (rsp.removed_value),
   .error         (rsp.error),
   .occupancy     (rsp.occupancy)
);
